[rtl/pws_pkg.sv]
`timescale 1ns / 1ps

package pws_pkg;

	localparam int ADDR_W   = 48;
	localparam int LEN_W    = 13;
	localparam int SRC_W    = 12;
	localparam int BYTES_W  = 8;
	localparam int DWORDS_W = 6;

	localparam logic [ADDR_W-1:0] FOUR_GIB = 48'h0001_0000_0000;

	typedef struct packed {
		logic [ADDR_W-1:0]   chunk_address;
		logic                wide_address;
		logic [DWORDS_W-1:0] dword_count;
		logic [3:0]          first_be;
		logic [3:0]          last_be;
		logic [SRC_W-1:0]    source_offset;
		logic [BYTES_W-1:0]  byte_count;
		logic [1:0]          lane_offset;
		logic                error;
		logic                last;
	} chunk_t;

	function automatic logic [3:0] low_enables(input logic [1:0] n);
		logic [3:0] be;
		case (n)
			2'd1:    be = 4'h1;
			2'd2:    be = 4'h3;
			2'd3:    be = 4'h7;
			default: be = 4'hf;
		endcase
		return be;
	endfunction

endpackage

[rtl/pws_chunk_unit.sv]
`timescale 1ns / 1ps

module pws_chunk_unit
	import pws_pkg::*;
#(
	parameter int CHUNK_BYTES = 128
) (
	input  logic [ADDR_W-1:0] addr,
	input  logic [LEN_W-1:0]  remain,
	input  logic [SRC_W-1:0]  src,
	input  logic              err,
	output chunk_t            chunk,
	output logic [LEN_W-1:0]  take,
	output logic [ADDR_W-1:0] next_addr
);

	localparam int CW = $clog2(CHUNK_BYTES);

	logic [1:0]       lane;
	logic             lead;
	logic [2:0]       lead_room;
	logic [LEN_W-1:0] lead_take;
	logic [3:0]       lead_en;
	logic [6:0]       lead_sh;
	logic [CW:0]      room;
	logic [LEN_W-1:0] main_take;
	logic [LEN_W-1:0] dw_sum;

	assign lane      = addr[1:0];
	assign lead      = (lane != 2'd0);
	assign lead_room = 3'd4 - {1'b0, lane};
	assign lead_take = (remain < LEN_W'(lead_room)) ? remain : LEN_W'(lead_room);
	assign lead_en   = (remain < LEN_W'(3)) ? low_enables(remain[1:0]) : 4'hf;
	assign lead_sh   = {3'b000, lead_en} << lane;

	assign room      = (CW+1)'(CHUNK_BYTES) - {1'b0, addr[CW-1:0]};
	assign main_take = (LEN_W'(room) < remain) ? LEN_W'(room) : remain;
	assign dw_sum    = main_take + LEN_W'(3);

	always_comb begin
		chunk = '0;
		take  = '0;
		if (err) begin
			chunk.error = 1'b1;
			chunk.last  = 1'b1;
		end else if (lead) begin
			take                = lead_take;
			chunk.chunk_address = {addr[ADDR_W-1:2], 2'b00};
			chunk.dword_count   = DWORDS_W'(1);
			chunk.first_be      = lead_sh[3:0];
			chunk.lane_offset   = lane;
		end else begin
			take                = main_take;
			chunk.chunk_address = addr;
			if (main_take <= LEN_W'(4)) begin
				chunk.dword_count = DWORDS_W'(1);
				chunk.first_be    = low_enables(main_take[1:0]);
			end else begin
				chunk.dword_count = dw_sum[DWORDS_W+1:2];
				chunk.first_be    = 4'hf;
				chunk.last_be     = low_enables(main_take[1:0]);
			end
		end
		if (!err) begin
			chunk.source_offset = src;
			chunk.byte_count    = take[BYTES_W-1:0];
			chunk.last          = (remain == take);
		end
		chunk.wide_address = (chunk.chunk_address >= FOUR_GIB);
	end

	assign next_addr = addr + ADDR_W'(take);

endmodule

[rtl/pcie_write_splitter.sv]
`timescale 1ns / 1ps
// Memory write request splitter.
// Input channel (in_valid/in_ready) takes one request: byte address and length.
// Output channel (out_valid/out_ready) gives one transaction per write chunk:
// an optional leading single-dword chunk for an unaligned start, then chunks
// ending on CHUNK_BYTES boundaries or at the request's end. last marks the
// final transaction of a request. A length above MAX_BYTES gives one
// transaction with error set; a zero length gives none.
// The request is first captured into the sequencer registers; each chunk is
// then computed from them and held in the output register. Throughput: one
// chunk per cycle while the receiver accepts, from a single shared chunk unit.
// in_ready is low while a request is being split and rises once its final
// chunk sits in the output register, so the next request is taken while that
// chunk waits.
// When the receiver stalls, the output register holds and the sequencer waits.
// Reset empties the output register and returns the sequencer to idle.
// CHUNK_BYTES must be a power of two.

module pcie_write_splitter
	import pws_pkg::*;
#(
	parameter int MAX_BYTES   = 4096,
	parameter int CHUNK_BYTES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ADDR_W-1:0]   address,
	input  logic [LEN_W-1:0]    length,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ADDR_W-1:0]   chunk_address,
	output logic                wide_address,
	output logic [DWORDS_W-1:0] dword_count,
	output logic [3:0]          first_be,
	output logic [3:0]          last_be,
	output logic [SRC_W-1:0]    source_offset,
	output logic [BYTES_W-1:0]  byte_count,
	output logic [1:0]          lane_offset,
	output logic                error,
	output logic                last
);

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              state_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  remain_q;
	logic [SRC_W-1:0]  src_q;
	logic              err_q;
	logic              out_valid_q;
	chunk_t            out_q;

	chunk_t            chunk;
	logic [LEN_W-1:0]  take;
	logic [ADDR_W-1:0] next_addr;
	logic              in_fire;
	logic              load;

	pws_chunk_unit #(
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_chunk (
		.addr     (addr_q),
		.remain   (remain_q),
		.src      (src_q),
		.err      (err_q),
		.chunk    (chunk),
		.take     (take),
		.next_addr(next_addr)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign load     = (state_q == ST_RUN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && length != '0) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (load && chunk.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q   <= address;
			remain_q <= length;
			src_q    <= '0;
			err_q    <= (length > MAX_LEN);
		end else if (load) begin
			addr_q   <= next_addr;
			remain_q <= remain_q - take;
			src_q    <= src_q + take[SRC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= chunk;
		end
	end

	assign out_valid     = out_valid_q;
	assign chunk_address = out_q.chunk_address;
	assign wide_address  = out_q.wide_address;
	assign dword_count   = out_q.dword_count;
	assign first_be      = out_q.first_be;
	assign last_be       = out_q.last_be;
	assign source_offset = out_q.source_offset;
	assign byte_count    = out_q.byte_count;
	assign lane_offset   = out_q.lane_offset;
	assign error         = out_q.error;
	assign last          = out_q.last;

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && byte_count == '0 && dword_count == '0)
		else $error("error transaction carries chunk data");

	a_lead_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lane_offset != 2'd0 |-> dword_count == DWORDS_W'(1) && last_be == 4'h0)
		else $error("leading partial chunk spans more than one dword");

	a_remain_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && !err_q |-> remain_q != '0 && remain_q <= MAX_LEN)
		else $error("remaining length out of range while splitting");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		load && chunk.last |=> in_ready)
		else $error("sequencer did not return to idle after final chunk");

endmodule

[tb/sv/pcie_write_splitter_test.sv]
`timescale 1ns / 1ps

module pcie_write_splitter_test
	import pws_pkg::*;
();

	localparam int MAX_BYTES   = 4096;
	localparam int CHUNK_BYTES = 128;

	class chunk_scoreboard;
		chunk_t pending[$];
		int     failures = 0;

		function logic [3:0] byte_mask(int n);
			if (n == 0 || n >= 4) begin
				return 4'hf;
			end
			return 4'hf >> (4 - n);
		endfunction

		function void push_chunk(chunk_t c);
			c.wide_address = (c.chunk_address >= FOUR_GIB);
			pending.push_back(c);
		endfunction

		function void note_request(logic [ADDR_W-1:0] a, logic [LEN_W-1:0] l);
			chunk_t            c;
			logic [ADDR_W-1:0] addr;
			int                remain;
			int                src;
			int                lane;
			int                take;
			logic [3:0]        be;
			addr   = a;
			remain = int'(l);
			src    = 0;
			if (remain == 0) begin
				return;
			end
			if (remain > MAX_BYTES) begin
				c       = '0;
				c.error = 1'b1;
				c.last  = 1'b1;
				pending.push_back(c);
				return;
			end
			if (addr[1:0] != 2'd0) begin
				lane = int'(addr[1:0]);
				take = (remain < 4 - lane) ? remain : 4 - lane;
				be   = (remain < 3) ? byte_mask(remain) : 4'hf;
				be   = be << lane;
				c                 = '0;
				c.chunk_address   = {addr[ADDR_W-1:2], 2'b00};
				c.dword_count     = 6'd1;
				c.first_be        = be;
				c.source_offset   = SRC_W'(src);
				c.byte_count      = BYTES_W'(take);
				c.lane_offset     = addr[1:0];
				c.last            = (remain == take);
				push_chunk(c);
				src    += take;
				remain -= take;
				addr   = addr + ADDR_W'(take);
			end
			while (remain != 0) begin
				take = CHUNK_BYTES - int'(addr % CHUNK_BYTES);
				if (take > remain) begin
					take = remain;
				end
				be              = byte_mask(take % 4);
				c               = '0;
				c.chunk_address = addr;
				c.source_offset = SRC_W'(src);
				c.byte_count    = BYTES_W'(take);
				c.last          = (remain == take);
				if (take <= 4) begin
					c.dword_count = 6'd1;
					c.first_be    = be;
					c.last_be     = 4'h0;
				end else begin
					c.dword_count = DWORDS_W'((take + 3) / 4);
					c.first_be    = 4'hf;
					c.last_be     = be;
				end
				push_chunk(c);
				src    += take;
				remain -= take;
				addr   = addr + ADDR_W'(take);
			end
		endfunction

		function void compare_field(string name, longint unsigned exp_v,
				longint unsigned got_v);
			if (exp_v != got_v) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
				failures++;
			end
		endfunction

		function void check_chunk(chunk_t got);
			chunk_t exp_c;
			if (pending.size() == 0) begin
				$error("unexpected transaction: chunk_address 0x%0h error %0b",
					got.chunk_address, got.error);
				failures++;
				return;
			end
			exp_c = pending.pop_front();
			compare_field("chunk_address", exp_c.chunk_address, got.chunk_address);
			compare_field("wide_address", exp_c.wide_address, got.wide_address);
			compare_field("dword_count", exp_c.dword_count, got.dword_count);
			compare_field("first_be", exp_c.first_be, got.first_be);
			compare_field("last_be", exp_c.last_be, got.last_be);
			compare_field("source_offset", exp_c.source_offset, got.source_offset);
			compare_field("byte_count", exp_c.byte_count, got.byte_count);
			compare_field("lane_offset", exp_c.lane_offset, got.lane_offset);
			compare_field("error", exp_c.error, got.error);
			compare_field("last", exp_c.last, got.last);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ADDR_W-1:0]   address = '0;
	logic [LEN_W-1:0]    length = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ADDR_W-1:0]   chunk_address;
	logic                wide_address;
	logic [DWORDS_W-1:0] dword_count;
	logic [3:0]          first_be;
	logic [3:0]          last_be;
	logic [SRC_W-1:0]    source_offset;
	logic [BYTES_W-1:0]  byte_count;
	logic [1:0]          lane_offset;
	logic                error;
	logic                last;

	chunk_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_len = 0;

	pcie_write_splitter #(
		.MAX_BYTES(MAX_BYTES),
		.CHUNK_BYTES(CHUNK_BYTES)
	) i_dut (.*);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_len != 0) begin
				hold_left    = hold_off_len;
				hold_off_len = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_chunk({chunk_address, wide_address, dword_count, first_be, last_be,
				source_offset, byte_count, lane_offset, error, last});
		end
	end

	task automatic send_request(input logic [ADDR_W-1:0] a, input logic [LEN_W-1:0] l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		address  <= a;
		length   <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_request(a, l);
	endtask

	task automatic random_request();
		logic [ADDR_W-1:0] a;
		logic [LEN_W-1:0]  l;
		case ($urandom_range(4))
			0: a = {16'($urandom), $urandom};
			1: a = ADDR_W'($urandom_range(1023));
			2: a = FOUR_GIB - ADDR_W'($urandom_range(300));
			3: a = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(300));
			default: a = {16'h0, $urandom};
		endcase
		case ($urandom_range(9)) inside
			0: l = LEN_W'($urandom_range(8));
			[6:7]: l = LEN_W'($urandom_range(MAX_BYTES, 1));
			8: l = LEN_W'($urandom_range(MAX_BYTES, MAX_BYTES - 8));
			9: l = LEN_W'($urandom_range(8191, MAX_BYTES + 1));
			default: l = LEN_W'($urandom_range(300, 1));
		endcase
		send_request(a, l);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(48'h0, 13'd0);
		send_request(48'h1000, 13'd4097);
		send_request({ADDR_W{1'b1}}, 13'd8191);
		send_request(48'h0, 13'd4096);
		send_request(48'h3, 13'd4096);
		send_request(48'h40, 13'd1);
		send_request(48'h44, 13'd2);
		send_request(48'h48, 13'd3);
		send_request(48'h4c, 13'd4);
		send_request(48'h51, 13'd1);
		send_request(48'h51, 13'd3);
		send_request(48'h52, 13'd2);
		send_request(48'h53, 13'd1);
		send_request(48'h53, 13'd5);
		send_request(48'h7c, 13'd8);
		send_request(48'h80, 13'd128);
		send_request(48'h7f, 13'd129);
		send_request(48'h0_ffff_fffe, 13'd10);
		send_request(48'hffff_ffff_fffd, 13'd100);
		send_request({ADDR_W{1'b1}}, 13'd1);
		send_request(48'haaaa_5555_aaa9, 13'd4095);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_off_len = 300; end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			repeat (37) random_request();
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
